@@ rtl/plal_pkg.sv @@
// types and constants shared by the polar linear arc length core
// depends on nothing; imported by polar_linear_arc_length_core, arc_length_checker and testbench
`timescale 1ns / 1ps

package plal_pkg;

   // result error codes
   localparam logic [2:0] ERR_NONE     = 3'd0;
   localparam logic [2:0] ERR_RS_ZERO  = 3'd1;
   localparam logic [2:0] ERR_RE_ZERO  = 3'd2;
   localparam logic [2:0] ERR_ANG_ZERO = 3'd3;
   localparam logic [2:0] ERR_ANG_BIG  = 3'd4;
   localparam logic [2:0] ERR_LOG_ARG  = 3'd5;

   // numeric constants
   localparam logic [31:0] PI_Q30  = 32'hC90FDAA2;
   localparam logic [31:0] LN2_Q32 = 32'hB17217F8;
   localparam logic [35:0] MAX36   = 36'hFFFFFFFFF;

   // pipeline schedule
   localparam int unsigned SQ_N   = 64;
   localparam int unsigned DIV_N  = 36;
   localparam int unsigned LOG_N  = 32;
   localparam int unsigned S_MUL  = 1;
   localparam int unsigned S_SQP  = 2;
   localparam int unsigned S_SUM  = 3;
   localparam int unsigned S_SQ0  = 4;
   localparam int unsigned S_A1   = S_SQ0 + SQ_N;
   localparam int unsigned S_A2   = S_A1 + 1;
   localparam int unsigned S_A3   = S_A2 + 1;
   localparam int unsigned S_D1   = S_A3 + 1;
   localparam int unsigned S_L0   = S_D1 + DIV_N;
   localparam int unsigned S_G1   = S_L0 + LOG_N;
   localparam int unsigned S_G2   = S_G1 + 1;
   localparam int unsigned S_G3   = S_G2 + 1;
   localparam int unsigned S_G4   = S_G3 + 1;
   localparam int unsigned S_G5   = S_G4 + 1;
   localparam int unsigned S_D2   = S_G5 + 1;
   localparam int unsigned S_FIN  = S_D2 + DIV_N;
   localparam int unsigned NST    = S_FIN + 1;

   // payload carried down the pipeline
   typedef struct packed {
      logic [2:0]   err;
      logic         eq;
      logic         re_gt;
      logic [35:0]  eq_len;
      logic [35:0]  len;
      logic [31:0]  d;
      logic [31:0]  rad_big;
      logic [31:0]  rad_sml;
      logic [31:0]  ang;
      logic [63:0]  a_big;
      logic [63:0]  a_sml;
      logic [63:0]  d2;
      logic [63:0]  pbm;
      logic [63:0]  psm;
      logic [127:0] nb;
      logic [127:0] ns;
      logic [63:0]  sb;
      logic [63:0]  ss;
      logic [64:0]  xb;
      logic [64:0]  xs;
      logic [6:0]   eb;
      logic [6:0]   es;
      logic [31:0]  mb;
      logic [31:0]  ms;
      logic [31:0]  fb;
      logic [31:0]  fs;
      logic [95:0]  num;
      logic         sat1;
      logic [32:0]  rem1;
      logic [35:0]  q1;
      logic [38:0]  g;
      logic [39:0]  lq;
      logic         sat2;
      logic [32:0]  rem2;
      logic [35:0]  q2;
   } work_type;

endpackage

@@ rtl/polar_linear_arc_length_core.sv @@
// polar linear arc length core: pipelined fixed-point arc length of a linear spiral
// depends on plal_pkg
`timescale 1ns / 1ps

// Takes one request per clock unless a result waits unaccepted at the result port, and
// returns one result per request, in order. The pipeline runs the 64 one-bit-per-stage
// square root stages, the two 36-stage restoring dividers and the 32 log2 squaring
// stages back to back. A stalled result port holds the whole pipeline, no request is
// lost. Radii are unsigned Q16.16, the angle is Q2.30 radians up to pi, the length is
// Q20.16 and saturates. Radii that differ by at most equal_radius_tolerance give
// radius_start times angle. Any input error forces the length to zero.
module polar_linear_arc_length_core
   import plal_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,   // radius_start, radius_end, angle_span
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // arc_length, error_code, zero pad
   input  logic        csr_tvalid,
   output logic        csr_tready,
   input  logic [15:0] csr_tdata    // equal_radius_tolerance
);

   logic [15:0] tol_ff;
   work_type    pipe_ff [NST];
   logic        valid_ff [NST];
   logic        adv;

   // index of the top set bit
   function automatic logic [6:0] top_bit(logic [64:0] x);
      logic [6:0] e;
      e = '0;
      for (int i = 0; i < 65; i++) begin
         if (x[i]) e = 7'(i);
      end
      return e;
   endfunction

   // one restoring divide step, remainder stays below the divisor
   function automatic logic [33:0] div_step(logic [32:0] rem, logic bin, logic [31:0] dv);
      logic [32:0] t;
      t = {rem[31:0], bin};
      if (t >= {1'b0, dv}) return {t - {1'b0, dv}, 1'b1};
      return {t, 1'b0};
   endfunction

   // one log2 fraction bit from squaring the mantissa
   function automatic logic [32:0] log_step(logic [31:0] m);
      logic [63:0] sq;
      sq = 64'(m) * 64'(m);
      if (sq[63]) return {sq[63:32], 1'b1};
      return {sq[62:31], 1'b0};
   endfunction

   // request capture and error checks
   function automatic work_type stage_in(logic [95:0] td, logic [15:0] tol);
      work_type    w;
      logic [31:0] rs, re, ang;
      w = '0;
      rs = td[31:0];
      re = td[63:32];
      ang = td[95:64];
      priority if (rs == '0) w.err = ERR_RS_ZERO;
      else if (re == '0) w.err = ERR_RE_ZERO;
      else if (ang == '0) w.err = ERR_ANG_ZERO;
      else if (ang > PI_Q30) w.err = ERR_ANG_BIG;
      else w.err = ERR_NONE;
      w.re_gt = re > rs;
      w.d = w.re_gt ? re - rs : rs - re;
      w.rad_big = w.re_gt ? re : rs;
      w.rad_sml = w.re_gt ? rs : re;
      w.ang = ang;
      w.eq = w.d <= {16'd0, tol};
      return w;
   endfunction

   // stage k work, k fixed per instance
   function automatic work_type stage_next(int unsigned k, work_type wi);
      work_type     w;
      logic [128:0] tb, ts;
      logic [33:0]  dr;
      logic [32:0]  lr;
      logic [95:0]  sh;
      logic [38:0]  lb, ls;
      int unsigned  b;
      w = wi;
      priority if (k == S_MUL) begin
         w.a_big = 64'(w.rad_big) * 64'(w.ang);
         w.a_sml = 64'(w.rad_sml) * 64'(w.ang);
         w.eq_len = w.re_gt ? {2'b0, w.a_sml[63:30]} : {2'b0, w.a_big[63:30]};
         w.d2 = 64'(w.d) * 64'(w.d);
      end else if (k == S_SQP) begin
         w.nb = {64'(w.a_big[63:32]) * 64'(w.a_big[63:32]),
                 64'(w.a_big[31:0]) * 64'(w.a_big[31:0])};
         w.ns = {64'(w.a_sml[63:32]) * 64'(w.a_sml[63:32]),
                 64'(w.a_sml[31:0]) * 64'(w.a_sml[31:0])};
         w.pbm = 64'(w.a_big[63:32]) * 64'(w.a_big[31:0]);
         w.psm = 64'(w.a_sml[63:32]) * 64'(w.a_sml[31:0]);
      end else if (k == S_SUM) begin
         w.nb = w.nb + {31'd0, w.pbm, 33'd0} + {4'd0, w.d2, 60'd0};
         w.ns = w.ns + {31'd0, w.psm, 33'd0} + {4'd0, w.d2, 60'd0};
         w.sb = '0;
         w.ss = '0;
      end else if (k >= S_SQ0 && k < S_A1) begin
         // square root, one root bit per stage, remainder in nb and ns
         b = SQ_N - 1 - (k - S_SQ0);
         tb = ({65'd0, w.sb} << (b + 1)) + (129'd1 << (2 * b));
         ts = ({65'd0, w.ss} << (b + 1)) + (129'd1 << (2 * b));
         if ({1'b0, w.nb} >= tb) begin
            w.nb = w.nb - tb[127:0];
            w.sb[b] = 1'b1;
         end
         if ({1'b0, w.ns} >= ts) begin
            w.ns = w.ns - ts[127:0];
            w.ss[b] = 1'b1;
         end
      end else if (k == S_A1) begin
         w.nb = {64'(w.rad_big) * 64'(w.sb[63:32]), 64'(w.rad_big) * 64'(w.sb[31:0])};
         w.ns = {64'(w.rad_sml) * 64'(w.ss[63:32]), 64'(w.rad_sml) * 64'(w.ss[31:0])};
         w.xb = 65'(w.sb) + 65'(w.a_big);
         w.xs = 65'(w.ss) + 65'(w.a_sml);
      end else if (k == S_A2) begin
         w.num = ({w.nb[127:64], 32'd0} + {32'd0, w.nb[63:0]})
               - ({w.ns[127:64], 32'd0} + {32'd0, w.ns[63:0]});
         w.eb = top_bit(w.xb);
         w.es = top_bit(w.xs);
      end else if (k == S_A3) begin
         // term one saturates when the quotient needs more than 36 bits
         w.sat1 = {3'd0, w.num[95:67]} >= w.d;
         w.rem1 = w.sat1 ? '0 : {4'd0, w.num[95:67]};
         w.q1 = '0;
         sh = {w.xb, 31'd0} >> w.eb;
         w.mb = sh[31:0];
         sh = {w.xs, 31'd0} >> w.es;
         w.ms = sh[31:0];
      end else if (k >= S_D1 && k < S_L0) begin
         b = DIV_N - 1 - (k - S_D1);
         dr = div_step(w.rem1, w.num[31 + b], w.d);
         w.rem1 = dr[33:1];
         w.q1[b] = dr[0];
      end else if (k >= S_L0 && k < S_G1) begin
         b = LOG_N - 1 - (k - S_L0);
         lr = log_step(w.mb);
         w.mb = lr[32:1];
         w.fb[b] = lr[0];
         lr = log_step(w.ms);
         w.ms = lr[32:1];
         w.fs[b] = lr[0];
      end else if (k == S_G1) begin
         lb = {w.eb, w.fb};
         ls = {w.es, w.fs};
         w.g = (lb >= ls) ? lb - ls : '0;
      end else if (k == S_G2) begin
         w.nb = {25'd0, 39'(w.g[38:32]) * 39'(LN2_Q32), 64'(w.g[31:0]) * 64'(LN2_Q32)};
      end else if (k == S_G3) begin
         w.lq = w.nb[103:64] + {8'd0, w.nb[63:32]};
      end else if (k == S_G4) begin
         w.nb = {24'd0, 40'(w.d) * 40'(w.lq[39:32]), 64'(w.d) * 64'(w.lq[31:0])};
      end else if (k == S_G5) begin
         // divide by 8*angle as a shift then a divide by the angle
         w.num = ({w.nb[127:64], 32'd0} + {32'd0, w.nb[63:0]}) >> 3;
         w.sat2 = w.num[68:36] >= {1'b0, w.ang};
         w.rem2 = w.sat2 ? '0 : w.num[68:36];
         w.q2 = '0;
      end else if (k >= S_D2 && k < S_FIN) begin
         b = DIV_N - 1 - (k - S_D2);
         dr = div_step(w.rem2, w.num[b], w.ang);
         w.rem2 = dr[33:1];
         w.q2[b] = dr[0];
      end else if (k == S_FIN) begin
         if (w.err != ERR_NONE) w.len = '0;
         else if (w.eq) w.len = w.eq_len;
         else begin
            lb = 39'(w.sat1 ? MAX36 : w.q1) + 39'(w.sat2 ? MAX36 : w.q2);
            w.len = (lb > 39'(MAX36)) ? MAX36 : lb[35:0];
         end
      end else begin
         w = wi;
      end
      return w;
   endfunction

   // pipeline advances unless a result waits
   assign adv = !valid_ff[NST-1] || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = valid_ff[NST-1];
   assign rsp_tdata = {1'b0, pipe_ff[NST-1].err, pipe_ff[NST-1].len};
   assign csr_tready = 1'b1;

   // tolerance register
   always_ff @(posedge clock) begin
      if (reset) tol_ff <= '0;
      else if (csr_tvalid) tol_ff <= csr_tdata;
   end

   // first stage
   always_ff @(posedge clock) begin
      if (reset) valid_ff[0] <= 1'b0;
      else if (adv) valid_ff[0] <= req_tvalid;
   end
   always_ff @(posedge clock) begin
      if (adv) pipe_ff[0] <= stage_in(req_tdata, tol_ff);
   end

   // remaining stages
   for (genvar k = 1; k < NST; k++) begin : g_stage
      always_ff @(posedge clock) begin
         if (reset) valid_ff[k] <= 1'b0;
         else if (adv) valid_ff[k] <= valid_ff[k-1];
      end
      always_ff @(posedge clock) begin
         if (adv) pipe_ff[k] <= stage_next(k, pipe_ff[k-1]);
      end
   end

   // checks
   a_no_log_err: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[38:36] < ERR_LOG_ARG)
      else $error("reserved error code on result");
   a_err_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[38:36] != ERR_NONE |-> rsp_tdata[35:0] == '0)
      else $error("error result with nonzero length");
   a_enter: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> valid_ff[0])
      else $error("accepted request not captured");

endmodule

@@ dv/arc_length_checker.sv @@
// checker for the polar linear arc length core: watches the request, result and csr
// channels, predicts each result in fixed point and compares in order
// depends on plal_pkg
`timescale 1ns / 1ps

module arc_length_checker
   import plal_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [95:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,
   input  logic        csr_tvalid,
   input  logic        csr_tready,
   input  logic [15:0] csr_tdata,
   output int          fail_count,
   output int          pending_count
);

   typedef struct packed {
      logic [35:0] arc_length;
      logic [2:0]  error_code;
   } arc_result_type;

   arc_result_type expected_arcs[$];
   logic [15:0] tolerance;

   assign pending_count = expected_arcs.size();

   // bitwise integer square root of a 128-bit value
   function automatic logic [63:0] isqrt128(input logic [127:0] n);
      logic [63:0] r;
      logic [63:0] t;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         t = r | (64'd1 << b);
         if (128'(t) * 128'(t) <= n) r = t;
      end
      return r;
   endfunction

   // log2 in Q.32 with 32 fraction bits by repeated squaring of the mantissa
   function automatic logic [95:0] log2_fixed(input logic [127:0] x);
      int e;
      logic [127:0] mant;
      logic [63:0] m;
      logic [31:0] frac;
      if (x == 0) return '0;
      e = 0;
      for (int i = 0; i < 128; i++) if (x[i]) e = i;
      mant = (e >= 31) ? (x >> (e - 31)) : (x << (31 - e));
      m = 64'(mant[31:0]);
      frac = '0;
      for (int i = 31; i >= 0; i--) begin
         m = (m * m) >> 31;
         if (m >= 64'h1_0000_0000) begin
            m = m >> 1;
            frac[i] = 1'b1;
         end
      end
      return (96'(e) << 32) | 96'(frac);
   endfunction

   function automatic logic [35:0] clamp36(input logic [127:0] v);
      return (v > 128'(MAX36)) ? MAX36 : v[35:0];
   endfunction

   function automatic arc_result_type predict_arc(input logic [95:0] data);
      logic [31:0] rs, re, ang, big, sml, d;
      logic [127:0] ab, as_, rho2, sb, ss, num, y1, y2, lb, ls, g, lq, total;
      arc_result_type res;
      rs = data[31:0];
      re = data[63:32];
      ang = data[95:64];
      res = '0;
      if (rs == 0) res.error_code = ERR_RS_ZERO;
      else if (re == 0) res.error_code = ERR_RE_ZERO;
      else if (ang == 0) res.error_code = ERR_ANG_ZERO;
      else if (ang > PI_Q30) res.error_code = ERR_ANG_BIG;
      else res.error_code = ERR_NONE;
      if (res.error_code != ERR_NONE) return res;
      d = (re > rs) ? re - rs : rs - re;
      if (d <= 32'(tolerance)) begin
         res.arc_length = 36'((64'(rs) * 64'(ang)) >> 30);
         return res;
      end
      big = (re > rs) ? re : rs;
      sml = (re > rs) ? rs : re;
      ab = 128'(big) * 128'(ang);
      as_ = 128'(sml) * 128'(ang);
      rho2 = (128'(d) << 30) * (128'(d) << 30);
      sb = 128'(isqrt128(ab * ab + rho2));
      ss = 128'(isqrt128(as_ * as_ + rho2));
      num = 128'(big) * sb - 128'(sml) * ss;
      y1 = 128'(clamp36(num / (128'(d) << 31)));
      lb = 128'(log2_fixed(sb + ab));
      ls = 128'(log2_fixed(ss + as_));
      g = (lb >= ls) ? lb - ls : 0;
      lq = (g * 128'(LN2_Q32)) >> 32;
      y2 = 128'(clamp36((128'(d) * lq) / (128'(ang) << 3)));
      total = y1 + y2;
      res.arc_length = clamp36(total);
      return res;
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      fail_count++;
   endtask

   initial fail_count = 0;

   // track csr writes, predict on request, compare on result
   always @(posedge clock) begin
      arc_result_type want;
      arc_result_type got;
      if (reset) begin
         tolerance <= '0;
      end else begin
         if (csr_tvalid && csr_tready) tolerance <= csr_tdata;
         if (req_tvalid && req_tready) expected_arcs.push_back(predict_arc(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got.arc_length = rsp_tdata[35:0];
            got.error_code = rsp_tdata[38:36];
            if (expected_arcs.size() == 0) begin
               report_mismatch("result with nothing pending");
            end else begin
               want = expected_arcs.pop_front();
               if (got.arc_length != want.arc_length)
                  report_mismatch($sformatf("arc_length %h want %h",
                                            got.arc_length, want.arc_length));
               if (got.error_code != want.error_code)
                  report_mismatch($sformatf("error_code %0d want %0d",
                                            got.error_code, want.error_code));
            end
         end
      end
   end

endmodule

@@ dv/testbench.sv @@
// top of the arc length regression: clock, reset, request and csr stimulus, verdict
// depends on plal_pkg, arc_length_checker and polar_linear_arc_length_core
`timescale 1ns / 1ps

module testbench
   import plal_pkg::*;
;

   localparam int PIPE_DEPTH = 181;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [95:0] req_tdata;    // radius_start, radius_end, angle_span
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;    // arc_length, error_code, zero pad
   logic        csr_tvalid;
   logic        csr_tready;
   logic [15:0] csr_tdata;    // equal_radius_tolerance
   int          fail_count;
   int          pending_count;
   logic        hold_off;

   polar_linear_arc_length_core u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_tvalid(csr_tvalid), .csr_tready(csr_tready), .csr_tdata(csr_tdata)
   );

   arc_length_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_tvalid(csr_tvalid), .csr_tready(csr_tready), .csr_tdata(csr_tdata),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   // clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   initial begin
      #20ms;
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic int gap_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 40) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // receiver: random stalls, one long hold-off on request
   initial begin
      int stall;
      int hold_cycles;
      bit hold_done;
      hold_done = 1'b0;
      rsp_tready = 1'b0;
      @(posedge clock iff !reset);
      forever begin
         if (hold_off && !hold_done) begin
            hold_done = 1'b1;
            rsp_tready <= 1'b0;
            hold_cycles = 0;
            while (hold_cycles < 2000) begin
               @(posedge clock);
               hold_cycles++;
            end
         end
         stall = gap_length();
         if (stall == 0 || $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end else begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   task automatic write_tolerance(input logic [15:0] value);
      csr_tvalid <= 1'b1;
      csr_tdata <= value;
      @(posedge clock);
      while (!csr_tready) @(posedge clock);
      csr_tvalid <= 1'b0;
   endtask

   task automatic send_request(input logic [31:0] rs, input logic [31:0] re,
                               input logic [31:0] ang, input bit allow_gap);
      int gap;
      gap = allow_gap ? gap_length() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {ang, re, rs};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 10) @(posedge clock);
   endtask

   // radius biased toward small, mid-range, power-of-two, and full range values
   function automatic logic [31:0] random_radius();
      case ($urandom_range(0, 4))
         0: return $urandom_range(1, 32'h0000_FFFF);
         1: return $urandom_range(1, 32'h00FF_FFFF);
         2: return 32'h0000_0001 << $urandom_range(0, 31);
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [31:0] random_angle();
      case ($urandom_range(0, 9))
         0: return $urandom();
         1: return $urandom_range(1, 255);
         2: return PI_Q30 - $urandom_range(0, 3);
         default: return $urandom_range(1, PI_Q30);
      endcase
   endfunction

   task automatic random_phase(input int count);
      logic [31:0] rs, re, ang;
      for (int i = 0; i < count; i++) begin
         rs = random_radius();
         case ($urandom_range(0, 5))
            0: re = rs + $urandom_range(0, 70000) - 35000;
            1: re = rs;
            default: re = random_radius();
         endcase
         ang = random_angle();
         if ($urandom_range(0, 39) == 0) rs = 0;
         if ($urandom_range(0, 39) == 0) re = 0;
         if ($urandom_range(0, 39) == 0) ang = 0;
         send_request(rs, re, ang, i % 100 > 20);
      end
   endtask

   // stimulus
   initial begin
      reset = 1'b1;
      hold_off = 1'b0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_tvalid = 1'b0;
      csr_tdata = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: errors and their precedence, extremes, equal radii
      send_request(0, 0, 0, 0);
      send_request(1, 0, 0, 0);
      send_request(1, 1, 0, 0);
      send_request(1, 1, PI_Q30 + 1, 0);
      send_request(1, 1, 32'hFFFF_FFFF, 0);
      send_request(1, 1, PI_Q30, 0);
      send_request(1, 1, 1, 0);
      send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, PI_Q30, 0);
      send_request(32'hFFFF_FFFF, 1, PI_Q30, 0);
      send_request(1, 32'hFFFF_FFFF, PI_Q30, 0);
      send_request(1, 32'hFFFF_FFFF, 1, 0);
      send_request(32'h0001_0000, 32'h0002_0000, 32'h4000_0000, 0);
      send_request(32'h0002_0000, 32'h0001_0000, 32'h4000_0000, 0);
      send_request(32'h0001_0000, 32'h0001_0001, 32'h4000_0000, 0);
      send_request(32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 0);
      send_request(32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 0);
      drain_results();

      write_tolerance(16'hFFFF);
      send_request(32'h0001_0000, 32'h0001_FFFF, 32'h4000_0000, 0);
      send_request(32'h0001_0000, 32'h0002_0000, 32'h4000_0000, 0);
      send_request(32'hFFFF_FFFF, 32'hFFFF_0000, PI_Q30, 0);
      random_phase(150);
      drain_results();

      // long receiver hold-off while requests keep coming
      write_tolerance(16'd0);
      hold_off = 1'b1;
      random_phase(300);
      hold_off = 1'b0;
      drain_results();

      write_tolerance(16'h0100);
      random_phase(200);
      drain_results();

      write_tolerance(16'($urandom()));
      random_phase(180);
      drain_results();

      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
